### rtl/parabolic_blend_trajectory_assert.svh
// Assertion macros for the parabolic blend trajectory generator
`ifndef PARABOLIC_BLEND_TRAJECTORY_ASSERT_SVH
`define PARABOLIC_BLEND_TRAJECTORY_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked after reset
`define PBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked after reset
`define PBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PBT_ASSERT_NOW(lbl, ante, cons, msg)
`define PBT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/pbt_pkg.sv
// Shared types and constants of the parabolic blend trajectory generator
`default_nettype none
package pbt_pkg;

  localparam int AXES = 6;
  localparam int AXW  = $clog2(AXES);
  localparam logic [AXW-1:0] LAST_AXIS = AXW'(AXES - 1);
  localparam logic [AXW-1:0] LIN_AXES  = AXW'(3);

  // request codes
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_SEG  = 2'd1;
  localparam logic [1:0] REQ_POSE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_VEL = 2'd1;
  localparam logic [1:0] ST_ACC = 2'd2;

  // configuration register indexes
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 20;
  localparam logic [CFG_IW-1:0] CFG_VEL_LIN = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_VEL_ROT = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_ACC_LIN = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ACC_ROT = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_FRAME   = 3'd4;

  // configuration reset values
  localparam logic [15:0] VEL_LIN_RST = 16'd400;
  localparam logic [15:0] VEL_ROT_RST = 16'd800;
  localparam logic [19:0] ACC_LIN_RST = 20'd50000;
  localparam logic [19:0] ACC_ROT_RST = 20'd10000;
  localparam logic [9:0]  FRAME_RST   = 10'd35;

  // scale factors of the limit checks
  localparam logic [63:0] SCALE_1E6 = 64'd1000000;
  localparam logic [63:0] SCALE_1E9 = 64'd1000000000;

  // shared unit operations
  localparam logic ALU_MUL = 1'b0;
  localparam logic ALU_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } alu_req_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] coord_0;
    logic signed [31:0] coord_1;
    logic signed [31:0] coord_2;
    logic signed [31:0] coord_3;
    logic signed [31:0] coord_4;
    logic signed [31:0] coord_5;
    logic [15:0]        duration_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pose_0;
    logic signed [31:0] pose_1;
    logic signed [31:0] pose_2;
    logic signed [31:0] pose_3;
    logic signed [31:0] pose_4;
    logic signed [31:0] pose_5;
    logic               busy_res;
    logic               last_frame;
  } out_word_t;

  // home pose, Q15.16
  function automatic logic signed [31:0] home_pose(input logic [AXW-1:0] idx);
    logic signed [31:0] v;
    case (idx)
      3'd0:    v = 32'sd144900;
      3'd1:    v = -32'sd228196;
      3'd2:    v = 32'sd66322;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/pbt_alu.sv
// Shared bit-serial multiplier and restoring divider, one bit per cycle
`default_nettype none
module pbt_alu (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pbt_pkg::alu_req_t req,
  input  wire logic [63:0]      opa,
  input  wire logic [63:0]      opb,
  output logic                  done,
  output logic [63:0]           res
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        op_r, op_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic [64:0] acc_r, acc_nxt;

  logic [64:0] rem_sh;
  logic [65:0] diff;

  // run one step of the selected operation
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    rem_sh   = {acc_r[63:0], a_r[63]};
    diff     = {1'b0, rem_sh} - {2'b00, b_r};
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = 6'd0;
      a_nxt    = opa;
      b_nxt    = opb;
      acc_nxt  = 65'd0;
    end else if (busy_r) begin
      if (op_r == pbt_pkg::ALU_MUL) begin
        acc_nxt = {1'b0, acc_r[63:0] + (b_r[0] ? a_r : 64'd0)};
        a_nxt   = {a_r[62:0], 1'b0};
        b_nxt   = {1'b0, b_r[63:1]};
      end else begin
        if (!diff[65]) begin
          acc_nxt = diff[64:0];
          a_nxt   = {a_r[62:0], 1'b1};
        end else begin
          acc_nxt = rem_sh;
          a_nxt   = {a_r[62:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign res  = (op_r == pbt_pkg::ALU_MUL) ? acc_r[63:0] : a_r;

endmodule
`default_nettype wire

### rtl/parabolic_blend_trajectory.sv
// Six-axis linear segment with parabolic blend trajectory generator, top level
// One item at a time; every multiply or divide runs on one shared unit.
// Tick while running: up to 2 operations on each of the 6 axes; an idle tick uses no operation.
// Segment request: up to 8 operations per axis; set pose uses no operation.
// The shared unit runs a 64-step loop per operation; the input is stalled while a request is in work.
// Synchronous active-low reset loads the home pose and the default limits.
`default_nettype none
module parabolic_blend_trajectory (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire pbt_pkg::in_word_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output pbt_pkg::out_word_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [pbt_pkg::CFG_IW-1:0]    cfg_idx,
  input  wire logic [pbt_pkg::CFG_DW-1:0]    cfg_wdata
);

  `include "parabolic_blend_trajectory_assert.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PDIFF = 4'd1;
  localparam logic [3:0] S_PQ    = 4'd2;
  localparam logic [3:0] S_PQC   = 4'd3;
  localparam logic [3:0] S_PR1   = 4'd4;
  localparam logic [3:0] S_PR2   = 4'd5;
  localparam logic [3:0] S_PCHK  = 4'd6;
  localparam logic [3:0] S_PVEL  = 4'd7;
  localparam logic [3:0] S_PDEN  = 4'd8;
  localparam logic [3:0] S_PACC  = 4'd9;
  localparam logic [3:0] S_ESEL  = 4'd10;
  localparam logic [3:0] S_EM1   = 4'd11;
  localparam logic [3:0] S_EFIN  = 4'd12;
  localparam logic [3:0] S_TEND  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  localparam logic [1:0] EM_IN     = 2'd0;
  localparam logic [1:0] EM_CRUISE = 2'd1;
  localparam logic [1:0] EM_OUT    = 2'd2;

  localparam int NA = pbt_pkg::AXES;
  localparam int AW = pbt_pkg::AXW;

  logic [3:0]         state_r, state_nxt;
  logic [AW-1:0]      axis_r, axis_nxt;
  pbt_pkg::in_word_t  in_r, in_nxt;
  logic signed [31:0] cur_r [NA];
  logic signed [31:0] cur_nxt [NA];
  logic signed [31:0] start_r [NA];
  logic signed [31:0] start_nxt [NA];
  logic signed [31:0] tgt_r [NA];
  logic signed [31:0] tgt_nxt [NA];
  logic [63:0]        acc_r [NA];
  logic [63:0]        acc_nxt [NA];
  logic [47:0]        vel_r [NA];
  logic [47:0]        vel_nxt [NA];
  logic [15:0]        tb_r [NA];
  logic [15:0]        tb_nxt [NA];
  logic [16:0]        elapsed_r, elapsed_nxt;
  logic [15:0]        seg_len_r, seg_len_nxt;
  logic               active_r, active_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               last_r, last_nxt;
  logic [32:0]        dm_r, dm_nxt;
  logic [15:0]        tbw_r, tbw_nxt;
  logic [15:0]        len_r, len_nxt;
  logic [63:0]        rr_r, rr_nxt;
  logic [17:0]        f_r, f_nxt;
  logic [1:0]         emode_r, emode_nxt;
  logic [63:0]        opa_r, opa_nxt;
  logic [63:0]        opb_r, opb_nxt;
  pbt_pkg::alu_req_t  alu_req_r, alu_req_nxt;
  logic [15:0]        vlin_r, vlin_nxt;
  logic [15:0]        vrot_r, vrot_nxt;
  logic [19:0]        alin_r, alin_nxt;
  logic [19:0]        arot_r, arot_nxt;
  logic [9:0]         frame_r, frame_nxt;
  pbt_pkg::out_word_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               alu_done;
  logic [63:0]        alu_res;
  logic signed [31:0] coord [NA];
  logic signed [31:0] in_coord [NA];

  // unpack the coordinates of the held and the incoming word
  always_comb begin
    coord[0]    = in_r.coord_0;
    coord[1]    = in_r.coord_1;
    coord[2]    = in_r.coord_2;
    coord[3]    = in_r.coord_3;
    coord[4]    = in_r.coord_4;
    coord[5]    = in_r.coord_5;
    in_coord[0] = in_data.coord_0;
    in_coord[1] = in_data.coord_1;
    in_coord[2] = in_data.coord_2;
    in_coord[3] = in_data.coord_3;
    in_coord[4] = in_data.coord_4;
    in_coord[5] = in_data.coord_5;
  end

  pbt_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req_r),
    .opa   (opa_r),
    .opb   (opb_r),
    .done  (alu_done),
    .res   (alu_res)
  );

  assign in_stall = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    logic signed [32:0] d;
    logic [15:0]        vlim;
    logic [19:0]        alim;
    logic [15:0]        dura;
    logic [15:0]        tb0;
    logic [15:0]        tbc;
    logic [16:0]        t2;
    logic [16:0]        tcur;
    logic [15:0]        tbe;
    logic [63:0]        m;
    logic               neg;
    logic               sub;
    logic signed [65:0] base;
    logic signed [65:0] sum;
    logic signed [31:0] sat;
    logic [16:0]        el;

    state_nxt     = state_r;
    axis_nxt      = axis_r;
    in_nxt        = in_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    tgt_nxt       = tgt_r;
    acc_nxt       = acc_r;
    vel_nxt       = vel_r;
    tb_nxt        = tb_r;
    elapsed_nxt   = elapsed_r;
    seg_len_nxt   = seg_len_r;
    active_nxt    = active_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    dm_nxt        = dm_r;
    tbw_nxt       = tbw_r;
    len_nxt       = len_r;
    rr_nxt        = rr_r;
    f_nxt         = f_r;
    emode_nxt     = emode_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    alu_req_nxt   = '0;
    vlin_nxt      = vlin_r;
    vrot_nxt      = vrot_r;
    alin_nxt      = alin_r;
    arot_nxt      = arot_r;
    frame_nxt     = frame_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    vlim = (axis_r < pbt_pkg::LIN_AXES) ? vlin_r : vrot_r;
    alim = (axis_r < pbt_pkg::LIN_AXES) ? alin_r : arot_r;
    dura = in_r.duration_ms;
    d    = {coord[axis_r][31], coord[axis_r]} - {cur_r[axis_r][31], cur_r[axis_r]};
    tb0  = dura - alu_res[15:0];
    tbc  = ({1'b0, tb0, 1'b0} > {2'b00, dura}) ? {1'b0, dura[15:1]} : tb0;
    tcur = elapsed_r;
    tbe  = tb_r[axis_r];
    t2   = {tcur[15:0], 1'b0} - {1'b0, tbe};
    m    = (emode_r == EM_CRUISE) ? ((alu_res + 64'd16384) >> 15)
                                  : ((alu_res + 64'h0000_0000_4000_0000) >> 31);
    neg  = tgt_r[axis_r] < start_r[axis_r];
    sub  = neg ^ (emode_r == EM_OUT);
    base = (emode_r == EM_OUT) ? 66'(tgt_r[axis_r]) : 66'(start_r[axis_r]);
    sum  = sub ? (base - $signed({2'b00, m})) : (base + $signed({2'b00, m}));
    if (sum > 66'sd2147483647) begin
      sat = 32'sh7FFF_FFFF;
    end else if (sum < -66'sd2147483648) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = sum[31:0];
    end
    el = elapsed_r + {7'd0, frame_r};

    // take configuration writes
    if (cfg_we) begin
      case (cfg_idx)
        pbt_pkg::CFG_VEL_LIN: vlin_nxt  = cfg_wdata[15:0];
        pbt_pkg::CFG_VEL_ROT: vrot_nxt  = cfg_wdata[15:0];
        pbt_pkg::CFG_ACC_LIN: alin_nxt  = cfg_wdata;
        pbt_pkg::CFG_ACC_ROT: arot_nxt  = cfg_wdata;
        pbt_pkg::CFG_FRAME:   frame_nxt = cfg_wdata[9:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt     = in_data;
          status_nxt = pbt_pkg::ST_OK;
          last_nxt   = 1'b0;
          axis_nxt   = '0;
          case (in_data.req_type)
            pbt_pkg::REQ_TICK: state_nxt = active_r ? S_ESEL : S_DONE;
            pbt_pkg::REQ_SEG:  state_nxt = S_PDIFF;
            pbt_pkg::REQ_POSE: begin
              cur_nxt    = in_coord;
              active_nxt = 1'b0;
              state_nxt  = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // plan: distance and first operation
      S_PDIFF: begin
        dm_nxt = d[32] ? 33'(-d) : 33'(d);
        if (d == 33'sd0) begin
          tb_nxt[axis_r]    = {1'b0, dura[15:1]};
          acc_nxt[axis_r]   = '0;
          vel_nxt[axis_r]   = '0;
          start_nxt[axis_r] = cur_r[axis_r];
          tgt_nxt[axis_r]   = coord[axis_r];
          if (axis_r == pbt_pkg::LAST_AXIS) begin
            seg_len_nxt = dura;
            elapsed_nxt = '0;
            active_nxt  = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            axis_nxt = axis_r + 1'b1;
          end
        end else if (vlim == 16'd0) begin
          status_nxt = pbt_pkg::ST_VEL;
          active_nxt = 1'b0;
          state_nxt  = S_DONE;
        end else begin
          opa_nxt     = {31'd0, (d[32] ? 33'(-d) : 33'(d))};
          opb_nxt     = pbt_pkg::SCALE_1E6;
          alu_req_nxt = '{start: 1'b1, op: pbt_pkg::ALU_MUL};
          state_nxt   = S_PQ;
        end
      end

      // ceil division for the time at the speed limit
      S_PQ: begin
        if (alu_done) begin
          opa_nxt     = alu_res + {16'd0, vlim, 16'd0} - 64'd1;
          opb_nxt     = {16'd0, vlim, 16'd0};
          alu_req_nxt = '{start: 1'b1, op: pbt_pkg::ALU_DIV};
          state_nxt   = S_PQC;
        end
      end

      // velocity check and blend time
      S_PQC: begin
        if (alu_done) begin
          if (alu_res > {48'd0, dura}) begin
            status_nxt = pbt_pkg::ST_VEL;
            active_nxt = 1'b0;
            state_nxt  = S_DONE;
          end else if (tbc == 16'd0) begin
            status_nxt = pbt_pkg::ST_ACC;
            active_nxt = 1'b0;
            state_nxt  = S_DONE;
          end else begin
            tbw_nxt     = tbc;
            len_nxt     = dura - tbc;
            opa_nxt     = {44'd0, alim};
            opb_nxt     = {48'd0, dura - tbc};
            alu_req_nxt = '{start: 1'b1, op: pbt_pkg::ALU_MUL};
            state_nxt   = S_PR1;
          end
        end
      end

      S_PR1: begin
        if (alu_done) begin
          opa_nxt     = alu_res;
          opb_nxt     = {48'd0, tbw_r};
          alu_req_nxt = '{start: 1'b1, op: pbt_pkg::ALU_MUL};
          state_nxt   = S_PR2;
        end
      end

      S_PR2: begin
        if (alu_done) begin
          rr_nxt      = alu_res;
          opa_nxt     = {31'd0, dm_r};
          opb_nxt     = pbt_pkg::SCALE_1E9;
          alu_req_nxt = '{start: 1'b1, op: pbt_pkg::ALU_MUL};
          state_nxt   = S_PCHK;
        end
      end

      // acceleration check, then cruise velocity
      S_PCHK: begin
        if (alu_done) begin
          if (rr_r < 64'h0000_8000_0000_0000 && alu_res > {rr_r[47:0], 16'd0}) begin
            status_nxt = pbt_pkg::ST_ACC;
            active_nxt = 1'b0;
            state_nxt  = S_DONE;
          end else begin
            opa_nxt     = {17'd0, dm_r, 14'd0} + {49'd0, len_r[15:1]};
            opb_nxt     = {48'd0, len_r};
            alu_req_nxt = '{start: 1'b1, op: pbt_pkg::ALU_DIV};
            state_nxt   = S_PVEL;
          end
        end
      end

      S_PVEL: begin
        if (alu_done) begin
          vel_nxt[axis_r] = alu_res[47:0];
          opa_nxt         = {48'd0, tbw_r};
          opb_nxt         = {48'd0, len_r};
          alu_req_nxt     = '{start: 1'b1, op: pbt_pkg::ALU_MUL};
          state_nxt       = S_PDEN;
        end
      end

      S_PDEN: begin
        if (alu_done) begin
          opa_nxt     = {1'b0, dm_r, 30'd0} + {1'b0, alu_res[63:1]};
          opb_nxt     = alu_res;
          alu_req_nxt = '{start: 1'b1, op: pbt_pkg::ALU_DIV};
          state_nxt   = S_PACC;
        end
      end

      // store the axis plan and advance
      S_PACC: begin
        if (alu_done) begin
          acc_nxt[axis_r]   = alu_res;
          tb_nxt[axis_r]    = tbw_r;
          start_nxt[axis_r] = cur_r[axis_r];
          tgt_nxt[axis_r]   = coord[axis_r];
          if (axis_r == pbt_pkg::LAST_AXIS) begin
            seg_len_nxt = dura;
            elapsed_nxt = '0;
            active_nxt  = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = S_PDIFF;
          end
        end
      end

      // evaluate: pick the profile piece
      S_ESEL: begin
        if (tcur <= {1'b0, tbe}) begin
          emode_nxt   = EM_IN;
          f_nxt       = {1'b0, tcur};
          opa_nxt     = acc_r[axis_r];
          opb_nxt     = {47'd0, tcur};
          alu_req_nxt = '{start: 1'b1, op: pbt_pkg::ALU_MUL};
          state_nxt   = S_EM1;
        end else if (tcur <= {1'b0, seg_len_r - tbe}) begin
          emode_nxt   = EM_CRUISE;
          opa_nxt     = {16'd0, vel_r[axis_r]};
          opb_nxt     = {47'd0, t2};
          alu_req_nxt = '{start: 1'b1, op: pbt_pkg::ALU_MUL};
          state_nxt   = S_EFIN;
        end else begin
          emode_nxt   = EM_OUT;
          f_nxt       = (tcur <= {1'b0, seg_len_r}) ? {2'b00, seg_len_r - tcur[15:0]} : 18'd0;
          opa_nxt     = acc_r[axis_r];
          opb_nxt     = (tcur <= {1'b0, seg_len_r}) ? {48'd0, seg_len_r - tcur[15:0]} : 64'd0;
          alu_req_nxt = '{start: 1'b1, op: pbt_pkg::ALU_MUL};
          state_nxt   = S_EM1;
        end
      end

      S_EM1: begin
        if (alu_done) begin
          opa_nxt     = alu_res;
          opb_nxt     = {46'd0, f_r};
          alu_req_nxt = '{start: 1'b1, op: pbt_pkg::ALU_MUL};
          state_nxt   = S_EFIN;
        end
      end

      // round, offset, saturate and store the pose
      S_EFIN: begin
        if (alu_done) begin
          cur_nxt[axis_r] = sat;
          if (axis_r == pbt_pkg::LAST_AXIS) begin
            state_nxt = S_TEND;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = S_ESEL;
          end
        end
      end

      // advance time, end the segment when it runs past its length
      S_TEND: begin
        elapsed_nxt = el;
        if (el > {1'b0, seg_len_r}) begin
          active_nxt = 1'b0;
          last_nxt   = 1'b1;
        end
        state_nxt = S_DONE;
      end

      // hand the result word over once the output register is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.status     = status_r;
          out_nxt.pose_0     = cur_r[0];
          out_nxt.pose_1     = cur_r[1];
          out_nxt.pose_2     = cur_r[2];
          out_nxt.pose_3     = cur_r[3];
          out_nxt.pose_4     = cur_r[4];
          out_nxt.pose_5     = cur_r[5];
          out_nxt.busy_res   = active_r;
          out_nxt.last_frame = last_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= '0;
      elapsed_r   <= '0;
      seg_len_r   <= '0;
      active_r    <= 1'b0;
      status_r    <= pbt_pkg::ST_OK;
      last_r      <= 1'b0;
      alu_req_r   <= '0;
      vlin_r      <= pbt_pkg::VEL_LIN_RST;
      vrot_r      <= pbt_pkg::VEL_ROT_RST;
      alin_r      <= pbt_pkg::ACC_LIN_RST;
      arot_r      <= pbt_pkg::ACC_ROT_RST;
      frame_r     <= pbt_pkg::FRAME_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NA; i++) begin
        cur_r[i] <= pbt_pkg::home_pose(AW'(i));
      end
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      elapsed_r   <= elapsed_nxt;
      seg_len_r   <= seg_len_nxt;
      active_r    <= active_nxt;
      status_r    <= status_nxt;
      last_r      <= last_nxt;
      alu_req_r   <= alu_req_nxt;
      vlin_r      <= vlin_nxt;
      vrot_r      <= vrot_nxt;
      alin_r      <= alin_nxt;
      arot_r      <= arot_nxt;
      frame_r     <= frame_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
    end
    in_r    <= in_nxt;
    start_r <= start_nxt;
    tgt_r   <= tgt_nxt;
    acc_r   <= acc_nxt;
    vel_r   <= vel_nxt;
    tb_r    <= tb_nxt;
    dm_r    <= dm_nxt;
    tbw_r   <= tbw_nxt;
    len_r   <= len_nxt;
    rr_r    <= rr_nxt;
    f_r     <= f_nxt;
    emode_r <= emode_nxt;
    opa_r   <= opa_nxt;
    opb_r   <= opb_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PBT_ASSERT_NOW(a_done_in_wait, alu_done,
    (state_r != S_IDLE && state_r != S_DONE && state_r != S_TEND && state_r != S_PDIFF),
    "shared unit finished outside a waiting state")
  `PBT_ASSERT_NOW(a_elapsed_bound, active_r, (elapsed_r <= {1'b0, seg_len_r}),
    "running segment past its length")
  `PBT_ASSERT_NOW(a_axis_range, 1'b1, (axis_r <= pbt_pkg::LAST_AXIS),
    "axis counter out of range")
  `PBT_ASSERT_NEXT(a_done_loads, (state_r == S_DONE && (!out_valid_r || !out_stall)),
    (out_valid_r && state_r == S_IDLE), "result word not loaded")

endmodule
`default_nettype wire

### sim/pbt_trajectory_checker.sv
// Checker for the parabolic blend trajectory generator: predicts and compares result words
module pbt_trajectory_checker
  import pbt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_word_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_word_t           out_data,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_idx,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  output int                  fail_cnt,
  output int                  pending,
  output int                  seg_ok_cnt,
  output int                  seg_rej_cnt,
  output int                  seg_end_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  // predictor copy of the limit registers
  logic [15:0] vlim_lin, vlim_rot;
  logic [19:0] alim_lin, alim_rot;
  logic [9:0]  frame_ms;

  // predictor copy of the trajectory state
  logic signed [31:0] pose_now [AXES];
  logic signed [31:0] pose_from [AXES];
  logic signed [31:0] pose_to [AXES];
  longint             accel_q46 [AXES];
  longint             vel_q30 [AXES];
  longint unsigned    blend_ms [AXES];
  logic [16:0]        elapsed;
  logic [15:0]        seg_len;
  logic               running;

  out_word_t expected_words [$];

  function automatic longint unsigned magnitude(input longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint signed_of(input longint unsigned m, input bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // plan one axis; returns a status code
  function automatic logic [1:0] plan_move(input int ax, input longint d,
                                           input longint unsigned dura,
                                           output longint unsigned tb_o,
                                           output longint acc_o, output longint vel_o);
    longint unsigned dm, vl, al, qc, tb, len, den, r;
    bit neg;
    dm = magnitude(d);
    neg = d < 0;
    vl = ax < 3 ? 64'(vlim_lin) : 64'(vlim_rot);
    al = ax < 3 ? 64'(alim_lin) : 64'(alim_rot);
    tb_o = 0;
    acc_o = 0;
    vel_o = 0;
    if (dm == 0) begin
      tb_o = dura >> 1;
      return ST_OK;
    end
    if (vl == 0) return ST_VEL;
    den = vl << 16;
    qc = (dm * 64'd1000000 + den - 1) / den;
    if (qc > dura) return ST_VEL;
    tb = dura - qc;
    if (2 * tb > dura) tb = dura >> 1;
    len = dura - tb;
    if (tb == 0) return ST_ACC;
    r = al * len * tb;
    if (r < (64'd1 << 47) && dm * 64'd1000000000 > (r << 16)) return ST_ACC;
    tb_o = tb;
    vel_o = signed_of(((dm << 14) + (len >> 1)) / len, neg);
    den = tb * len;
    acc_o = signed_of(((dm << 30) + (den >> 1)) / den, neg);
    return ST_OK;
  endfunction

  // position of one axis at elapsed time t
  function automatic logic signed [31:0] blend_pos(input int i, input longint unsigned t);
    longint s, q;
    longint unsigned tb, dur, am, vm, m, u;
    bit neg;
    s = pose_from[i];
    q = pose_to[i];
    neg = q < s;
    tb = blend_ms[i];
    dur = 64'(seg_len);
    am = magnitude(accel_q46[i]);
    vm = magnitude(vel_q30[i]);
    if (t <= tb) begin
      m = (am * t * t + (64'd1 << 30)) >> 31;
      return clamp32(s + signed_of(m, neg));
    end
    if (t <= dur - tb) begin
      m = (vm * (2 * t - tb) + (64'd1 << 14)) >> 15;
      return clamp32(s + signed_of(m, neg));
    end
    u = t <= dur ? dur - t : 0;
    m = (am * u * u + (64'd1 << 30)) >> 31;
    return clamp32(q - signed_of(m, neg));
  endfunction

  // advance the predictor by one accepted input word
  task automatic predict_word(input in_word_t w, output out_word_t e);
    logic signed [31:0] c [AXES];
    longint unsigned tbs [AXES];
    longint accs [AXES];
    longint vels [AXES];
    logic [1:0] st;
    logic last;
    int i;
    c[0] = w.coord_0; c[1] = w.coord_1; c[2] = w.coord_2;
    c[3] = w.coord_3; c[4] = w.coord_4; c[5] = w.coord_5;
    st = ST_OK;
    last = 1'b0;
    case (w.req_type)
      REQ_TICK: begin
        if (running) begin
          for (i = 0; i < AXES; i++) pose_now[i] = blend_pos(i, 64'(elapsed));
          elapsed = elapsed + 17'(frame_ms);
          if (elapsed > 17'(seg_len)) begin
            running = 1'b0;
            last = 1'b1;
            seg_end_cnt++;
          end
        end
      end
      REQ_SEG: begin
        for (i = 0; i < AXES && st == ST_OK; i++)
          st = plan_move(i, longint'(c[i]) - longint'(pose_now[i]), 64'(w.duration_ms),
                         tbs[i], accs[i], vels[i]);
        if (st != ST_OK) begin
          running = 1'b0;
          seg_rej_cnt++;
        end else begin
          for (i = 0; i < AXES; i++) begin
            pose_from[i] = pose_now[i];
            pose_to[i] = c[i];
            blend_ms[i] = tbs[i];
            accel_q46[i] = accs[i];
            vel_q30[i] = vels[i];
          end
          seg_len = w.duration_ms;
          elapsed = '0;
          running = 1'b1;
          seg_ok_cnt++;
        end
      end
      REQ_POSE: begin
        for (i = 0; i < AXES; i++) pose_now[i] = c[i];
        running = 1'b0;
      end
      default: ;
    endcase
    e.status = st;
    e.pose_0 = pose_now[0]; e.pose_1 = pose_now[1]; e.pose_2 = pose_now[2];
    e.pose_3 = pose_now[3]; e.pose_4 = pose_now[4]; e.pose_5 = pose_now[5];
    e.busy_res = running;
    e.last_frame = last;
  endtask

  // compare one result word against the oldest expectation
  task automatic check_word(input out_word_t g);
    out_word_t e;
    longint ev [9];
    longint gv [9];
    string nm [9];
    int k;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, g);
      fail_cnt++;
      return;
    end
    e = expected_words.pop_front();
    nm = '{"status", "pose_0", "pose_1", "pose_2", "pose_3", "pose_4", "pose_5",
           "busy_res", "last_frame"};
    ev = '{e.status, e.pose_0, e.pose_1, e.pose_2, e.pose_3, e.pose_4, e.pose_5,
           e.busy_res, e.last_frame};
    gv = '{g.status, g.pose_0, g.pose_1, g.pose_2, g.pose_3, g.pose_4, g.pose_5,
           g.busy_res, g.last_frame};
    for (k = 0; k < 9; k++) begin
      if (ev[k] != gv[k] || $isunknown(g)) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm[k], ev[k], gv[k]);
        fail_cnt++;
      end
    end
  endtask

  // track reset, register writes and both channels
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      fail_cnt = 0;
      seg_ok_cnt = 0;
      seg_rej_cnt = 0;
      seg_end_cnt = 0;
      vlim_lin = VEL_LIN_RST;
      vlim_rot = VEL_ROT_RST;
      alim_lin = ACC_LIN_RST;
      alim_rot = ACC_ROT_RST;
      frame_ms = FRAME_RST;
      pose_now = '{32'sd144900, -32'sd228196, 32'sd66322, 32'sd0, 32'sd0, 32'sd0};
      for (int i = 0; i < AXES; i++) begin
        pose_from[i] = '0;
        pose_to[i] = '0;
        accel_q46[i] = 0;
        vel_q30[i] = 0;
        blend_ms[i] = 0;
      end
      elapsed = '0;
      seg_len = '0;
      running = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_VEL_LIN: vlim_lin = cfg_wdata[15:0];
          CFG_VEL_ROT: vlim_rot = cfg_wdata[15:0];
          CFG_ACC_LIN: alim_lin = cfg_wdata[19:0];
          CFG_ACC_ROT: alim_rot = cfg_wdata[19:0];
          CFG_FRAME:   frame_ms = cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_word(in_data, e);
        expected_words.insert(expected_words.size(), e);
      end
      if (out_valid && !out_stall) check_word(out_data);
    end
    pending = expected_words.size();
  end

endmodule

### sim/tb_parabolic_blend_trajectory.sv
// Testbench top for the parabolic blend trajectory generator: stimulus and verdict
module tb_parabolic_blend_trajectory;
  timeunit 1ns;
  timeprecision 1ps;
  import pbt_pkg::*;

  localparam int IDLE_LIMIT = 40000;
  // request code the block ignores
  localparam logic [1:0] REQ_BAD = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_word_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  out_word_t         out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_idx = CFG_VEL_LIN;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  int fail_cnt, pending, seg_ok_cnt, seg_rej_cnt, seg_end_cnt;
  int words_sent = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  // stimulus view of the limits and the pose it aims from
  longint unsigned vl_lin, vl_rot, al_lin, al_rot, frame_now;
  logic signed [31:0] aim_pose [AXES];
  logic signed [31:0] coords [AXES];

  parabolic_blend_trajectory dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  pbt_trajectory_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .fail_cnt(fail_cnt), .pending(pending), .seg_ok_cnt(seg_ok_cnt),
    .seg_rej_cnt(seg_rej_cnt), .seg_end_cnt(seg_end_cnt)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d words pending", $time, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random hold-offs, one long hold on request
  initial begin
    int w;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      w = calm ? 0 : $urandom_range(0, 17);
      if (hold_req) begin
        hold_req = 1'b0;
        w = 6000;
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic in_word_t build_word(input logic [1:0] rt, input logic [15:0] dur);
    in_word_t w;
    w.req_type = rt;
    w.coord_0 = coords[0]; w.coord_1 = coords[1]; w.coord_2 = coords[2];
    w.coord_3 = coords[3]; w.coord_4 = coords[4]; w.coord_5 = coords[5];
    w.duration_ms = dur;
    return w;
  endfunction

  // offer one word after a random gap and hold it until taken
  task automatic send_word(input in_word_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.req_type != REQ_BAD) words_sent++;
  endtask

  task automatic send_req(input logic [1:0] rt, input logic [15:0] dur);
    send_word(build_word(rt, dur));
  endtask

  task automatic set_coords(input logic signed [31:0] v);
    for (int i = 0; i < AXES; i++) coords[i] = v;
  endtask

  task automatic coords_home();
    coords = '{32'sd144900, -32'sd228196, 32'sd66322, 32'sd0, 32'sd0, 32'sd0};
  endtask

  // drain, then write all five limit registers
  task automatic write_limits(input logic [19:0] vlin, input logic [19:0] vrot,
                              input logic [19:0] alin, input logic [19:0] arot,
                              input logic [19:0] frm);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_VEL_LIN; cfg_wdata <= vlin; @(posedge clk);
    cfg_idx <= CFG_VEL_ROT; cfg_wdata <= vrot; @(posedge clk);
    cfg_idx <= CFG_ACC_LIN; cfg_wdata <= alin; @(posedge clk);
    cfg_idx <= CFG_ACC_ROT; cfg_wdata <= arot; @(posedge clk);
    cfg_idx <= CFG_FRAME;   cfg_wdata <= frm;  @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    vl_lin = vlin[15:0];
    vl_rot = vrot[15:0];
    al_lin = alin;
    al_rot = arot;
    frame_now = frm[9:0];
  endtask

  // move: optional pose load, a target near or just past the limits of reach, then ticks
  task automatic run_move();
    longint unsigned dur, half, mv, ma, mx;
    longint dl;
    int n;
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < AXES; i++) aim_pose[i] = $urandom_range(0, 3) == 0 ?
          $urandom : clamp32(longint'($signed($urandom)) >>> 2);
      coords = aim_pose;
      send_req(REQ_POSE, 16'd0);
    end
    if (frame_now == 0) dur = $urandom_range(1, 300);
    else dur = frame_now * $urandom_range(1, 8) + $urandom_range(0, frame_now);
    if ($urandom_range(0, 40) == 0) dur = $urandom_range(0, 1) ? 0 : 65535;
    if (dur > 65535) dur = 65535;
    half = dur / 2;
    for (int i = 0; i < AXES; i++) begin
      mv = (i < 3 ? vl_lin : vl_rot) * 65536 * dur / 1000000 / 2;
      ma = (i < 3 ? al_lin : al_rot) * half * half / 1000 * 65536 / 1000000;
      mx = mv < ma ? mv : ma;
      if (mx > (64'd1 << 30)) mx = 64'd1 << 30;
      mx = mx * 5 / 4 + 1;
      dl = longint'({$urandom, $urandom} % mx);
      if ($urandom_range(0, 1)) dl = -dl;
      if ($urandom_range(0, 5) == 0) dl = 0;
      coords[i] = clamp32(longint'(aim_pose[i]) + dl);
    end
    aim_pose = coords;
    send_req(REQ_SEG, dur[15:0]);
    n = frame_now == 0 ? 4 : int'(dur / frame_now) + 2;
    if (n > 12) n = 12;
    if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
    repeat (n) send_req(REQ_TICK, 16'($urandom));
  endtask

  // noise: any code, any field value
  task automatic run_noise();
    logic [1:0] rt;
    rt = $urandom_range(0, 3);
    for (int i = 0; i < AXES; i++) coords[i] = $urandom;
    if (rt == REQ_POSE) aim_pose = coords;
    send_req(rt, 16'($urandom));
  endtask

  task automatic run_random(input int count);
    int goal;
    goal = words_sent + count;
    while (words_sent < goal) begin
      if ($urandom_range(0, 149) == 0) calm = !calm;
      if ($urandom_range(0, 9) < 7) run_move();
      else run_noise();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_limits(20'd400, 20'd800, 20'd50000, 20'd10000, 20'd35);

    // directed: idle tick, ignored code, extreme poses and targets
    coords_home();
    send_req(REQ_TICK, 16'd0);
    send_req(REQ_BAD, 16'hffff);
    set_coords(32'sh7fffffff);
    send_req(REQ_POSE, 16'd0);
    set_coords(32'sh80000000);
    send_req(REQ_SEG, 16'hffff);
    send_req(REQ_POSE, 16'd0);
    set_coords(32'sh7fffffff);
    send_req(REQ_SEG, 16'd0);
    // zero-length move to the same spot, ended by one tick
    coords_home();
    send_req(REQ_POSE, 16'd0);
    send_req(REQ_SEG, 16'd0);
    send_req(REQ_TICK, 16'd0);
    send_req(REQ_TICK, 16'd0);
    // short move, then replace it while running
    for (int i = 0; i < AXES; i++) coords[i] = coords[i] + 2000;
    send_req(REQ_SEG, 16'd700);
    repeat (3) send_req(REQ_TICK, 16'd0);
    for (int i = 0; i < AXES; i++) coords[i] = coords[i] - 5000;
    send_req(REQ_SEG, 16'd350);
    send_req(REQ_TICK, 16'd0);
    send_req(REQ_BAD, 16'd0);
    // pose load aborts the move
    coords_home();
    send_req(REQ_POSE, 16'd0);
    send_req(REQ_TICK, 16'd0);
    // acceleration fault on a rotary axis, then zero blend time
    coords[3] = 32'sd1000;
    send_req(REQ_SEG, 16'd40);
    coords_home();
    coords[0] = coords[0] + 1;
    send_req(REQ_SEG, 16'd1);
    send_req(REQ_TICK, 16'd0);
    coords_home();
    send_req(REQ_POSE, 16'd0);
    aim_pose = coords;

    // random phases over several limit settings
    hold_req = 1'b1;
    run_random(250);
    write_limits(20'd65535, 20'd65535, 20'd1000000, 20'd1048575, 20'd1000);
    run_random(250);
    write_limits(20'd1, 20'd1, 20'd1, 20'd1, 20'd1);
    run_random(250);
    write_limits(20'd3000, 20'd5000, 20'd200000, 20'd300000, 20'd10);
    run_random(250);
    write_limits(20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
    run_random(100);

    // drain and settle
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    $display("Sent %0d words under five limit settings: %0d moves planned, %0d rejected,",
             words_sent, seg_ok_cnt, seg_rej_cnt);
    $display("%0d moves ran to their end; %0d mismatches", seg_end_cnt, fail_cnt);
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
